@@ rtl/bitmap_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Concurrent assertion shorthands used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bitmap_block_allocator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bitmap_block_allocator: assertion failed");

`else

`define BBA_ASSERT_IMP(name, ck, rn, ante, cons)
`define BBA_ASSERT_NEXT(name, ck, rn, ante, cons)

`endif

`endif

@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Sizes, field widths, request and status codes shared by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	localparam int DATA_BITS   = 4096;
	localparam int INODE_BITS  = 1024;

	localparam int WORD_W      = 32;
	localparam int WORD_AW     = $clog2(WORD_W);
	localparam int CHUNK_W     = 8;
	localparam int CHUNK_AW    = $clog2(CHUNK_W);
	localparam int CHUNKS      = WORD_W / CHUNK_W;
	localparam int CH_W        = $clog2(CHUNKS);

	localparam int DATA_WORDS  = (DATA_BITS + WORD_W - 1) / WORD_W;
	localparam int INODE_WORDS = (INODE_BITS + WORD_W - 1) / WORD_W;
	localparam int DATA_AW     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam int INODE_AW    = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
	localparam int PTR_W       = (DATA_AW > INODE_AW) ? DATA_AW : INODE_AW;

	localparam int DFREE_W     = $clog2(DATA_BITS + 1);
	localparam int IFREE_W     = $clog2(INODE_BITS + 1);
	localparam int FREE_W      = (DFREE_W > IFREE_W) ? DFREE_W : IFREE_W;

	localparam int REQ_W       = 3;
	localparam int IDX_W       = 12;
	localparam int LEN_W       = 13;
	localparam int STAT_W      = 2;
	localparam int FL_W        = 13;
	localparam int DENT_W      = 13;
	localparam int IENT_W      = 11;
	localparam int CFG_W       = 13;
	localparam int RUN_W       = (DFREE_W > LEN_W) ? DFREE_W : LEN_W;

	localparam logic [DENT_W-1:0] DENT_RST = DENT_W'(4096);
	localparam logic [IENT_W-1:0] IENT_RST = IENT_W'(1024);

	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic              cfg_idx_t;

	localparam req_t REQ_TEST  = 3'd0;
	localparam req_t REQ_SET   = 3'd1;
	localparam req_t REQ_CLEAR = 3'd2;
	localparam req_t REQ_FIND  = 3'd3;
	localparam req_t REQ_RUN   = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_REFUSED   = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;
	localparam status_t ST_INVALID   = 2'd3;

	localparam cfg_idx_t CFG_DATA_ENTRIES  = 1'b0;
	localparam cfg_idx_t CFG_INODE_ENTRIES = 1'b1;

endpackage

`default_nettype wire

@@ rtl/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a data block bitmap and an inode bitmap.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on status, is_used, found_index and free_left, marked by done, which is
// high for exactly one cycle; the receiver cannot stall it. A new request
// may be started in the cycle that done is high.
// Both bitmaps live in 32-bit word RAMs with a registered read. A request
// that needs no bitmap access finishes in the check state; test reads one
// word; set and clear read one word and write it back when the bit changes.
// A first-free search examines one word a cycle, and a free-run search
// takes 8 bits a cycle.
// Configuration writes (index 0 data size, index 1 inode size) are taken
// while busy is low; a write empties its map at once through per-word valid
// flags and reloads the free count with the new size.
// After reset both maps are empty, the sizes are 4096 and 1024, and the
// block is ready in the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bba_pkg::REQ_W-1:0]     req_type,
	input  logic                          map_sel,
	input  logic [bba_pkg::IDX_W-1:0]     entry_index,
	input  logic [bba_pkg::LEN_W-1:0]     run_length,
	output logic                          done,
	output logic [bba_pkg::STAT_W-1:0]    status,
	output logic                          is_used,
	output logic [bba_pkg::IDX_W-1:0]     found_index,
	output logic [bba_pkg::FL_W-1:0]      free_left,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bba_pkg::CFG_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_ACCESS,
		S_SCAN
	} state_t;

	state_t                             state_q;
	state_t                             nxt_state;
	logic                               done_q;
	bba_pkg::status_t                   status_q;
	logic                               is_used_q;
	logic [bba_pkg::IDX_W-1:0]          found_index_q;
	logic [bba_pkg::FL_W-1:0]           free_left_q;

	bba_pkg::req_t                      req_type_q;
	logic                               map_sel_q;
	logic [bba_pkg::IDX_W-1:0]          entry_index_q;
	logic [bba_pkg::LEN_W-1:0]          run_length_q;

	logic [bba_pkg::DENT_W-1:0]         data_entries_q;
	logic [bba_pkg::IENT_W-1:0]         inode_entries_q;
	logic [bba_pkg::DFREE_W-1:0]        data_free_q;
	logic [bba_pkg::IFREE_W-1:0]        inode_free_q;

	logic [bba_pkg::PTR_W-1:0]          ptr_q;
	logic [bba_pkg::CH_W-1:0]           ch_q;
	logic [bba_pkg::FREE_W-1:0]         rem_q;
	logic [bba_pkg::RUN_W-1:0]          cnt_q;

	logic [bba_pkg::DATA_WORDS-1:0]     dvalid_q;
	logic [bba_pkg::INODE_WORDS-1:0]    ivalid_q;
	logic                               dvld_s1;
	logic                               ivld_s1;

	logic [bba_pkg::DFREE_W-1:0]        data_size;
	logic [bba_pkg::IFREE_W-1:0]        inode_size;
	logic [bba_pkg::FREE_W-1:0]         cur_size;
	logic [bba_pkg::FREE_W-1:0]         cur_free;
	logic [bba_pkg::FREE_W-1:0]         fin_free;
	logic                               idx_oor;
	logic [bba_pkg::PTR_W-1:0]          idx_word;
	logic [bba_pkg::WORD_AW-1:0]        bit_sel;
	logic [bba_pkg::PTR_W-1:0]          rd_ptr;
	logic [bba_pkg::DATA_AW-1:0]        d_raddr;
	logic [bba_pkg::INODE_AW-1:0]       i_raddr;
	logic [bba_pkg::DATA_AW-1:0]        d_waddr;
	logic [bba_pkg::INODE_AW-1:0]       i_waddr;
	logic [bba_pkg::WORD_W-1:0]         d_rdata;
	logic [bba_pkg::WORD_W-1:0]         i_rdata;
	logic [bba_pkg::WORD_W-1:0]         rd_word;
	logic [bba_pkg::WORD_W-1:0]         wr_word;
	logic [bba_pkg::WORD_W-1:0]         bit_mask;
	logic                               cur_bit;
	logic                               mem_wr;
	logic                               d_we;
	logic                               i_we;
	logic                               cfg_fire;
	logic                               last_chunk;
	logic                               last_word;

	logic [bba_pkg::WORD_W-1:0]         in_range;
	logic [bba_pkg::WORD_W-1:0]         avail;
	logic                               ff_hit;
	logic [bba_pkg::WORD_AW-1:0]        ff_pos;
	logic [bba_pkg::IDX_W-1:0]          ff_found;
	logic [bba_pkg::CHUNK_W-1:0]        chunk_free;
	logic [bba_pkg::RUN_W-1:0]          run_cnt;
	logic                               run_hit;
	logic [bba_pkg::CHUNK_AW-1:0]       run_pos;
	logic [bba_pkg::IDX_W-1:0]          run_found;

	logic                               fin;
	bba_pkg::status_t                   fin_status;
	logic                               fin_used;
	logic [bba_pkg::IDX_W-1:0]          fin_found;
	logic                               free_inc;
	logic                               free_dec;

	function automatic logic [bba_pkg::DFREE_W-1:0] data_eff(
		input logic [bba_pkg::DENT_W-1:0] e
	);
		if (32'(e) < 32'(bba_pkg::DATA_BITS)) begin
			return bba_pkg::DFREE_W'(e);
		end
		return bba_pkg::DFREE_W'(bba_pkg::DATA_BITS);
	endfunction

	function automatic logic [bba_pkg::IFREE_W-1:0] inode_eff(
		input logic [bba_pkg::IENT_W-1:0] e
	);
		if (32'(e) < 32'(bba_pkg::INODE_BITS)) begin
			return bba_pkg::IFREE_W'(e);
		end
		return bba_pkg::IFREE_W'(bba_pkg::INODE_BITS);
	endfunction

	assign busy        = (state_q != S_IDLE);
	assign cfg_ready   = (state_q == S_IDLE);
	assign cfg_fire    = cfg_valid && cfg_ready;
	assign done        = done_q;
	assign status      = status_q;
	assign is_used     = is_used_q;
	assign found_index = found_index_q;
	assign free_left   = free_left_q;

	assign data_size  = data_eff(data_entries_q);
	assign inode_size = inode_eff(inode_entries_q);
	assign cur_size   = map_sel_q ? bba_pkg::FREE_W'(inode_size) : bba_pkg::FREE_W'(data_size);
	assign cur_free   = map_sel_q ? bba_pkg::FREE_W'(inode_free_q)
		: bba_pkg::FREE_W'(data_free_q);
	assign fin_free   = cur_free + bba_pkg::FREE_W'(free_inc) - bba_pkg::FREE_W'(free_dec);

	assign idx_oor  = (32'(entry_index_q) >= 32'(cur_size));
	assign idx_word = bba_pkg::PTR_W'(entry_index_q >> bba_pkg::WORD_AW);
	assign bit_sel  = entry_index_q[bba_pkg::WORD_AW-1:0];
	assign bit_mask = bba_pkg::WORD_W'(1) << bit_sel;

	assign last_chunk = (ch_q == bba_pkg::CH_W'(bba_pkg::CHUNKS - 1));
	assign last_word  = (32'(rem_q) <= 32'(bba_pkg::WORD_W));

	always_comb begin
		unique case (state_q)
			S_CHECK: begin
				if (req_type_q == bba_pkg::REQ_FIND || req_type_q == bba_pkg::REQ_RUN) begin
					rd_ptr = '0;
				end else begin
					rd_ptr = idx_word;
				end
			end
			S_SCAN: begin
				if (req_type_q == bba_pkg::REQ_RUN && !last_chunk) begin
					rd_ptr = ptr_q;
				end else begin
					rd_ptr = ptr_q + 1'b1;
				end
			end
			default: begin
				rd_ptr = idx_word;
			end
		endcase
	end

	assign d_raddr = bba_pkg::DATA_AW'(rd_ptr);
	assign i_raddr = bba_pkg::INODE_AW'(rd_ptr);
	assign d_waddr = bba_pkg::DATA_AW'(idx_word);
	assign i_waddr = bba_pkg::INODE_AW'(idx_word);

	// A word whose valid flag is clear has not been written since its map was emptied.
	assign rd_word = map_sel_q ? (ivld_s1 ? i_rdata : '0) : (dvld_s1 ? d_rdata : '0);
	assign cur_bit = rd_word[bit_sel];
	assign wr_word = (req_type_q == bba_pkg::REQ_SET) ? (rd_word | bit_mask)
		: (rd_word & ~bit_mask);

	assign mem_wr = (state_q == S_ACCESS)
		&& ((req_type_q == bba_pkg::REQ_SET && !cur_bit)
		|| (req_type_q == bba_pkg::REQ_CLEAR && cur_bit));
	assign d_we = mem_wr && !map_sel_q;
	assign i_we = mem_wr && map_sel_q;

	bba_ram #(
		.WIDTH (bba_pkg::WORD_W),
		.DEPTH (bba_pkg::DATA_WORDS)
	) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (wr_word),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	bba_ram #(
		.WIDTH (bba_pkg::WORD_W),
		.DEPTH (bba_pkg::INODE_WORDS)
	) u_inode_ram (
		.clk   (clk),
		.we    (i_we),
		.waddr (i_waddr),
		.wdata (wr_word),
		.raddr (i_raddr),
		.rdata (i_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q <= '0;
			ivalid_q <= '0;
			dvld_s1  <= 1'b0;
			ivld_s1  <= 1'b0;
		end else begin
			dvld_s1 <= dvalid_q[d_raddr];
			ivld_s1 <= ivalid_q[i_raddr];
			if (cfg_fire && cfg_index == bba_pkg::CFG_DATA_ENTRIES) begin
				dvalid_q <= '0;
			end else if (d_we) begin
				dvalid_q[d_waddr] <= 1'b1;
			end
			if (cfg_fire && cfg_index == bba_pkg::CFG_INODE_ENTRIES) begin
				ivalid_q <= '0;
			end else if (i_we) begin
				ivalid_q[i_waddr] <= 1'b1;
			end
		end
	end

	// Bits at or beyond the map size count as used.
	always_comb begin
		for (int b = 0; b < bba_pkg::WORD_W; b++) begin
			in_range[b] = (32'(b) < 32'(rem_q));
		end
	end

	assign avail = ~rd_word & in_range;

	always_comb begin
		ff_hit = |avail;
		ff_pos = '0;
		for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
			if (avail[b]) begin
				ff_pos = bba_pkg::WORD_AW'(b);
			end
		end
	end

	assign ff_found = bba_pkg::IDX_W'((32'(ptr_q) << bba_pkg::WORD_AW) + 32'(ff_pos));

	assign chunk_free = bba_pkg::CHUNK_W'(avail >> (32'(ch_q) << bba_pkg::CHUNK_AW));

	always_comb begin
		run_cnt = cnt_q;
		run_hit = 1'b0;
		run_pos = '0;
		for (int j = 0; j < bba_pkg::CHUNK_W; j++) begin
			run_cnt = chunk_free[j] ? (run_cnt + 1'b1) : '0;
			if (!run_hit && run_cnt == bba_pkg::RUN_W'(run_length_q)) begin
				run_hit = 1'b1;
				run_pos = bba_pkg::CHUNK_AW'(j);
			end
		end
	end

	assign run_found = bba_pkg::IDX_W'((32'(ptr_q) << bba_pkg::WORD_AW)
		+ (32'(ch_q) << bba_pkg::CHUNK_AW) + 32'(run_pos) + 32'd1 - 32'(run_length_q));

	always_comb begin
		nxt_state  = state_q;
		fin        = 1'b0;
		fin_status = bba_pkg::ST_OK;
		fin_used   = 1'b0;
		fin_found  = '0;
		free_inc   = 1'b0;
		free_dec   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					nxt_state = S_CHECK;
				end
			end
			S_CHECK: begin
				nxt_state = S_IDLE;
				unique case (req_type_q)
					bba_pkg::REQ_TEST: begin
						if (cur_free == '0) begin
							fin      = 1'b1;
							fin_used = 1'b1;
						end else if (idx_oor) begin
							fin        = 1'b1;
							fin_status = bba_pkg::ST_INVALID;
						end else begin
							nxt_state = S_ACCESS;
						end
					end
					bba_pkg::REQ_SET: begin
						if (cur_free == '0) begin
							fin        = 1'b1;
							fin_status = bba_pkg::ST_REFUSED;
						end else if (idx_oor) begin
							fin        = 1'b1;
							fin_status = bba_pkg::ST_INVALID;
						end else begin
							nxt_state = S_ACCESS;
						end
					end
					bba_pkg::REQ_CLEAR: begin
						if (idx_oor) begin
							fin        = 1'b1;
							fin_status = bba_pkg::ST_INVALID;
						end else begin
							nxt_state = S_ACCESS;
						end
					end
					bba_pkg::REQ_FIND: begin
						if (cur_free == '0) begin
							fin        = 1'b1;
							fin_status = bba_pkg::ST_NOT_FOUND;
						end else begin
							nxt_state = S_SCAN;
						end
					end
					bba_pkg::REQ_RUN: begin
						if (map_sel_q || run_length_q == '0) begin
							fin        = 1'b1;
							fin_status = bba_pkg::ST_INVALID;
						end else if (cur_free == '0) begin
							fin        = 1'b1;
							fin_status = bba_pkg::ST_NOT_FOUND;
						end else begin
							nxt_state = S_SCAN;
						end
					end
					default: begin
						fin        = 1'b1;
						fin_status = bba_pkg::ST_INVALID;
					end
				endcase
			end
			S_ACCESS: begin
				fin = 1'b1;
				unique case (req_type_q)
					bba_pkg::REQ_TEST: begin
						fin_used = cur_bit;
					end
					bba_pkg::REQ_SET: begin
						if (cur_bit) begin
							fin_status = bba_pkg::ST_REFUSED;
						end else begin
							free_dec = 1'b1;
						end
					end
					bba_pkg::REQ_CLEAR: begin
						if (!cur_bit) begin
							fin_status = bba_pkg::ST_REFUSED;
						end else begin
							free_inc = 1'b1;
						end
					end
					default: begin
						fin_status = bba_pkg::ST_INVALID;
					end
				endcase
			end
			S_SCAN: begin
				if (req_type_q == bba_pkg::REQ_RUN) begin
					if (run_hit) begin
						fin       = 1'b1;
						fin_found = run_found;
					end else if (last_chunk && last_word) begin
						fin        = 1'b1;
						fin_status = bba_pkg::ST_NOT_FOUND;
					end
				end else begin
					if (ff_hit) begin
						fin       = 1'b1;
						fin_found = ff_found;
					end else if (last_word) begin
						fin        = 1'b1;
						fin_status = bba_pkg::ST_NOT_FOUND;
					end
				end
			end
		endcase
		if (fin) begin
			nxt_state = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			done_q          <= 1'b0;
			status_q        <= bba_pkg::ST_OK;
			is_used_q       <= 1'b0;
			found_index_q   <= '0;
			free_left_q     <= '0;
			req_type_q      <= bba_pkg::REQ_TEST;
			map_sel_q       <= 1'b0;
			entry_index_q   <= '0;
			run_length_q    <= '0;
			data_entries_q  <= bba_pkg::DENT_RST;
			inode_entries_q <= bba_pkg::IENT_RST;
			data_free_q     <= data_eff(bba_pkg::DENT_RST);
			inode_free_q    <= inode_eff(bba_pkg::IENT_RST);
			ptr_q           <= '0;
			ch_q            <= '0;
			rem_q           <= '0;
			cnt_q           <= '0;
		end else begin
			state_q <= nxt_state;
			done_q  <= fin;

			if (state_q == S_IDLE && start) begin
				req_type_q    <= req_type;
				map_sel_q     <= map_sel;
				entry_index_q <= entry_index;
				run_length_q  <= run_length;
			end

			if (state_q == S_CHECK) begin
				ptr_q <= '0;
				ch_q  <= '0;
				cnt_q <= '0;
				rem_q <= cur_size;
			end else if (state_q == S_SCAN && !fin) begin
				if (req_type_q == bba_pkg::REQ_RUN) begin
					cnt_q <= run_cnt;
					if (last_chunk) begin
						ch_q  <= '0;
						ptr_q <= ptr_q + 1'b1;
						rem_q <= rem_q - bba_pkg::FREE_W'(bba_pkg::WORD_W);
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end else begin
					ptr_q <= ptr_q + 1'b1;
					rem_q <= rem_q - bba_pkg::FREE_W'(bba_pkg::WORD_W);
				end
			end

			if (fin) begin
				status_q      <= fin_status;
				is_used_q     <= fin_used;
				found_index_q <= fin_found;
				free_left_q   <= bba_pkg::FL_W'(fin_free);
			end

			if (free_dec) begin
				if (map_sel_q) begin
					inode_free_q <= inode_free_q - 1'b1;
				end else begin
					data_free_q <= data_free_q - 1'b1;
				end
			end else if (free_inc) begin
				if (map_sel_q) begin
					inode_free_q <= inode_free_q + 1'b1;
				end else begin
					data_free_q <= data_free_q + 1'b1;
				end
			end

			if (cfg_fire) begin
				unique case (cfg_index)
					bba_pkg::CFG_DATA_ENTRIES: begin
						data_entries_q <= bba_pkg::DENT_W'(cfg_data);
						data_free_q    <= data_eff(bba_pkg::DENT_W'(cfg_data));
					end
					bba_pkg::CFG_INODE_ENTRIES: begin
						inode_entries_q <= bba_pkg::IENT_W'(cfg_data);
						inode_free_q    <= inode_eff(bba_pkg::IENT_W'(cfg_data));
					end
				endcase
			end
		end
	end

	`BBA_ASSERT_IMP(a_done_when_idle, clk, arst_n, done, !busy)
	`BBA_ASSERT_NEXT(a_start_goes_busy, clk, arst_n, start && !busy, busy && !done)
	`BBA_ASSERT_IMP(a_write_in_access, clk, arst_n, d_we || i_we, state_q == S_ACCESS)
	`BBA_ASSERT_IMP(a_free_bounds, clk, arst_n, 1'b1, (32'(data_free_q) <= 32'(data_size)) && (32'(inode_free_q) <= 32'(inode_size)))

endmodule

`default_nettype wire

@@ rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Issues test, set, clear, first-free and free-run requests to both bitmaps
// under several size settings and compares every result item, field by field,
// with a cycle-free model of both maps and free counts, or a directed row.
// ----------------------------------------------------------------------------

module testbench;
	import bba_pkg::*;

	localparam req_t REQ_BAD_FIRST = 3'd5;
	localparam req_t REQ_BAD_LAST  = 3'd7;
	localparam int   NUM_PHASES    = 8;
	localparam int   TAIL_CYCLES   = 20;

	typedef struct packed {
		status_t             st;
		logic                used;
		logic [IDX_W-1:0]    found;
		logic [FL_W-1:0]     free_cnt;
	} alloc_result_t;

	typedef struct packed {
		req_t                req;
		logic                sel;
		logic [IDX_W-1:0]    idx;
		logic [LEN_W-1:0]    len;
		logic                typed;
		alloc_result_t       want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [REQ_W-1:0]    req_type;
	logic                map_sel;
	logic [IDX_W-1:0]    entry_index;
	logic [LEN_W-1:0]    run_length;
	logic                done;
	logic [STAT_W-1:0]   status;
	logic                is_used;
	logic [IDX_W-1:0]    found_index;
	logic [FL_W-1:0]     free_left;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	bit                  data_bitmap [DATA_BITS];
	bit                  inode_bitmap [INODE_BITS];
	int unsigned         data_size;
	int unsigned         inode_size;
	int unsigned         data_free_cnt;
	int unsigned         inode_free_cnt;

	alloc_result_t       pending_results [$];
	dir_row_t            directed_rows [$];
	int unsigned         mismatch_count;
	int unsigned         items_issued;
	int unsigned         results_seen;
	int unsigned         status_hist [4];

	int phase_data [NUM_PHASES]  = '{16, 40, 1, 8191, 0, 100, 4096, 8};
	int phase_inode [NUM_PHASES] = '{8, 33, 1, 8191, 0, 64, 1024, 16};
	int phase_idle [NUM_PHASES]  = '{9, 45, 0, 9, 45, 0, 45, 0};
	int phase_items [NUM_PHASES] = '{260, 260, 120, 150, 60, 260, 120, 200};

	bitmap_block_allocator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.map_sel     (map_sel),
		.entry_index (entry_index),
		.run_length  (run_length),
		.done        (done),
		.status      (status),
		.is_used     (is_used),
		.found_index (found_index),
		.free_left   (free_left),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic bit map_bit(logic sel, int unsigned i);
		return sel ? inode_bitmap[i] : data_bitmap[i];
	endfunction

	function automatic alloc_result_t predict_alloc(req_t req, logic sel,
			logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
		alloc_result_t r;
		int unsigned size;
		int unsigned freec;
		int unsigned run;
		r = '0;
		size = sel ? inode_size : data_size;
		freec = sel ? inode_free_cnt : data_free_cnt;
		case (req)
			REQ_TEST: begin
				if (freec == 0)
					r.used = 1'b1;
				else if (idx >= size)
					r.st = ST_INVALID;
				else
					r.used = map_bit(sel, idx);
			end
			REQ_SET: begin
				if (freec == 0 || (idx < size && map_bit(sel, idx)))
					r.st = ST_REFUSED;
				else if (idx >= size)
					r.st = ST_INVALID;
				else begin
					if (sel)
						inode_bitmap[idx] = 1'b1;
					else
						data_bitmap[idx] = 1'b1;
					freec--;
				end
			end
			REQ_CLEAR: begin
				if (idx >= size)
					r.st = ST_INVALID;
				else if (!map_bit(sel, idx))
					r.st = ST_REFUSED;
				else begin
					if (sel)
						inode_bitmap[idx] = 1'b0;
					else
						data_bitmap[idx] = 1'b0;
					freec++;
				end
			end
			REQ_FIND: begin
				r.st = ST_NOT_FOUND;
				if (freec != 0) begin
					for (int unsigned i = 0; i < size; i++) begin
						if (!map_bit(sel, i)) begin
							r.st = ST_OK;
							r.found = i[IDX_W-1:0];
							break;
						end
					end
				end
			end
			REQ_RUN: begin
				if (sel || len == 0)
					r.st = ST_INVALID;
				else begin
					r.st = ST_NOT_FOUND;
					run = 0;
					if (freec != 0) begin
						for (int unsigned i = 0; i < size; i++) begin
							run = data_bitmap[i] ? 0 : run + 1;
							if (run == len) begin
								r.st = ST_OK;
								r.found = IDX_W'(i + 1 - len);
								break;
							end
						end
					end
				end
			end
			default: r.st = ST_INVALID;
		endcase
		if (sel)
			inode_free_cnt = freec;
		else
			data_free_cnt = freec;
		r.free_cnt = freec[FL_W-1:0];
		return r;
	endfunction

	task automatic add_row(req_t req, logic sel, int idx, int len, logic typed,
			status_t st, logic used, int found, int free_cnt);
		dir_row_t row;
		row.req = req;
		row.sel = sel;
		row.idx = IDX_W'(idx);
		row.len = LEN_W'(len);
		row.typed = typed;
		row.want.st = st;
		row.want.used = used;
		row.want.found = IDX_W'(found);
		row.want.free_cnt = FL_W'(free_cnt);
		directed_rows.push_back(row);
	endtask

	task automatic issue_request(req_t req, logic sel, logic [IDX_W-1:0] idx,
			logic [LEN_W-1:0] len, logic typed, alloc_result_t want, int idle_pct);
		alloc_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		map_sel <= sel;
		entry_index <= idx;
		run_length <= len;
		do
			@(posedge clk);
		while (busy);
		predicted = predict_alloc(req, sel, idx, len);
		pending_results.push_back(typed ? want : predicted);
		items_issued++;
	endtask

	task automatic random_request(bit filling, int idle_pct);
		logic sel;
		int unsigned size;
		int unsigned top;
		int unsigned r;
		req_t req;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		sel = $urandom_range(1);
		size = sel ? inode_size : data_size;
		r = $urandom_range(99);
		if (r < 15)
			req = REQ_TEST;
		else if (r < (filling ? 55 : 25))
			req = REQ_SET;
		else if (r < (filling ? 65 : 62))
			req = REQ_CLEAR;
		else if (r < 77)
			req = REQ_FIND;
		else if (r < 93)
			req = REQ_RUN;
		else
			req = req_t'($urandom_range(REQ_BAD_LAST, REQ_BAD_FIRST));
		r = $urandom_range(99);
		top = (size + 1 > 4095) ? 4095 : size + 1;
		if (r < 80)
			idx = IDX_W'($urandom_range(top, 0));
		else if (r < 90)
			idx = (size == 0) ? '0 : IDX_W'(size - 1 + $urandom_range(1));
		else
			idx = IDX_W'($urandom);
		r = $urandom_range(99);
		if (r < 50)
			len = LEN_W'($urandom_range(8, 1));
		else if (r < 75)
			len = LEN_W'($urandom_range(size + 2, 1));
		else if (r < 85)
			len = '0;
		else
			len = LEN_W'($urandom);
		issue_request(req, sel, idx, len, 1'b0, '0, idle_pct);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size(cfg_idx_t which, logic [CFG_W-1:0] value);
		int unsigned entries;
		cfg_index <= which;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (which == CFG_DATA_ENTRIES) begin
			entries = value;
			data_size = (entries < DATA_BITS) ? entries : DATA_BITS;
			foreach (data_bitmap[i])
				data_bitmap[i] = 1'b0;
			data_free_cnt = data_size;
		end else begin
			entries = value & 13'h07FF;
			inode_size = (entries < INODE_BITS) ? entries : INODE_BITS;
			foreach (inode_bitmap[i])
				inode_bitmap[i] = 1'b0;
			inode_free_cnt = inode_size;
		end
	endtask

	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && done) begin
			results_seen++;
			status_hist[status]++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item, status %0d", $time, status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d, got %0d", $time, want.st, status);
					mismatch_count++;
				end
				if (is_used !== want.used) begin
					$display("%0t: is_used expected %0d, got %0d", $time, want.used,
						is_used);
					mismatch_count++;
				end
				if (found_index !== want.found) begin
					$display("%0t: found_index expected %0d, got %0d", $time, want.found,
						found_index);
					mismatch_count++;
				end
				if (free_left !== want.free_cnt) begin
					$display("%0t: free_left expected %0d, got %0d", $time, want.free_cnt,
						free_left);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_TEST;
		map_sel = 1'b0;
		entry_index = '0;
		run_length = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DATA_ENTRIES;
		cfg_data = '0;
		mismatch_count = 0;
		items_issued = 0;
		results_seen = 0;
		data_size = DATA_BITS;
		inode_size = INODE_BITS;
		data_free_cnt = DATA_BITS;
		inode_free_cnt = INODE_BITS;

		add_row(REQ_TEST, 1'b0, 0, 1, 1'b1, ST_OK, 1'b0, 0, 4096);
		add_row(REQ_TEST, 1'b0, 4095, 8191, 1'b1, ST_OK, 1'b0, 0, 4096);
		add_row(REQ_TEST, 1'b1, 1023, 0, 1'b1, ST_OK, 1'b0, 0, 1024);
		add_row(REQ_TEST, 1'b1, 1024, 0, 1'b1, ST_INVALID, 1'b0, 0, 1024);
		add_row(REQ_SET, 1'b0, 0, 0, 1'b1, ST_OK, 1'b0, 0, 4095);
		add_row(REQ_SET, 1'b0, 0, 0, 1'b1, ST_REFUSED, 1'b0, 0, 4095);
		add_row(REQ_SET, 1'b0, 4095, 0, 1'b1, ST_OK, 1'b0, 0, 4094);
		add_row(REQ_FIND, 1'b0, 0, 0, 1'b1, ST_OK, 1'b0, 1, 4094);
		add_row(REQ_CLEAR, 1'b0, 5, 0, 1'b1, ST_REFUSED, 1'b0, 0, 4094);
		add_row(REQ_CLEAR, 1'b0, 0, 0, 1'b1, ST_OK, 1'b0, 0, 4095);
		add_row(REQ_FIND, 1'b0, 0, 0, 1'b1, ST_OK, 1'b0, 0, 4095);
		add_row(REQ_RUN, 1'b0, 0, 0, 1'b1, ST_INVALID, 1'b0, 0, 4095);
		add_row(REQ_RUN, 1'b1, 0, 1, 1'b1, ST_INVALID, 1'b0, 0, 1024);
		add_row(REQ_RUN, 1'b0, 0, 4096, 1'b1, ST_NOT_FOUND, 1'b0, 0, 4095);
		add_row(REQ_RUN, 1'b0, 0, 4095, 1'b1, ST_OK, 1'b0, 0, 4095);
		add_row(REQ_RUN, 1'b0, 4095, 8191, 1'b1, ST_NOT_FOUND, 1'b0, 0, 4095);
		add_row(REQ_BAD_FIRST, 1'b0, 0, 1, 1'b1, ST_INVALID, 1'b0, 0, 4095);
		add_row(REQ_BAD_FIRST + 1, 1'b1, 3, 1, 1'b1, ST_INVALID, 1'b0, 0, 1024);
		add_row(REQ_BAD_LAST, 1'b0, 4095, 8191, 1'b1, ST_INVALID, 1'b0, 0, 4095);
		add_row(REQ_SET, 1'b1, 1023, 0, 1'b1, ST_OK, 1'b0, 0, 1023);
		add_row(REQ_FIND, 1'b1, 0, 0, 1'b1, ST_OK, 1'b0, 0, 1023);
		add_row(REQ_SET, 1'b1, 0, 0, 1'b0, ST_OK, 1'b0, 0, 0);
		add_row(REQ_RUN, 1'b0, 0, 1, 1'b0, ST_OK, 1'b0, 0, 0);
		add_row(REQ_CLEAR, 1'b0, 4095, 0, 1'b1, ST_OK, 1'b0, 0, 4096);
		add_row(REQ_CLEAR, 1'b1, 4095, 0, 1'b1, ST_INVALID, 1'b0, 0, 1022);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			issue_request(directed_rows[k].req, directed_rows[k].sel, directed_rows[k].idx,
				directed_rows[k].len, directed_rows[k].typed, directed_rows[k].want, 9);

		for (int p = 0; p < NUM_PHASES; p++) begin
			start <= 1'b0;
			drain_results();
			write_size(CFG_DATA_ENTRIES, CFG_W'(phase_data[p]));
			write_size(CFG_INODE_ENTRIES, CFG_W'(phase_inode[p]));
			for (int n = 0; n < phase_items[p]; n++)
				random_request(((n / 40) % 2) == 0, phase_idle[p]);
		end

		start <= 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d requests over %0d size settings, %0d results, %0d mismatches",
			items_issued, NUM_PHASES + 1, results_seen, mismatch_count);
		$display("summary: status ok %0d, refused %0d, not found %0d, invalid %0d",
			status_hist[ST_OK], status_hist[ST_REFUSED], status_hist[ST_NOT_FOUND],
			status_hist[ST_INVALID]);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
